FILE: rtl/ictf_pkg.sv
package ictf_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TabLen = 24;
  localparam int unsigned AngW = 20;
  localparam int unsigned VecW = 30;

  localparam logic [8:0] WeightReset = 9'd192;
  localparam logic [8:0] WeightMax = 9'd256;
  localparam logic [0:0] RegAccelWeight = 1'b0;

  // Arctangent of 2^-i in units of 1/256 tenth of a degree.
  function automatic logic [16:0] atan_tab(input logic [4:0] idx);
    logic [16:0] r;
    begin
      case (idx)
        5'd0: r = 17'd115200;
        5'd1: r = 17'd68007;
        5'd2: r = 17'd35933;
        5'd3: r = 17'd18240;
        5'd4: r = 17'd9155;
        5'd5: r = 17'd4582;
        5'd6: r = 17'd2292;
        5'd7: r = 17'd1146;
        5'd8: r = 17'd573;
        5'd9: r = 17'd286;
        5'd10: r = 17'd143;
        5'd11: r = 17'd72;
        5'd12: r = 17'd36;
        5'd13: r = 17'd18;
        5'd14: r = 17'd9;
        5'd15: r = 17'd4;
        5'd16: r = 17'd2;
        5'd17: r = 17'd1;
        5'd18: r = 17'd1;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

  // Control and results between the lanes and the merging stage.
  typedef struct packed {
    logic                   done;
    logic signed [15:0]     tilt_x;
    logic signed [15:0]     tilt_y;
    logic signed [15:0]     tilt_z;
  } lane_res_t;

endpackage

FILE: rtl/ictf_cordic_lane.sv
// One iterative CORDIC atan2 lane: one rotation per cycle.
module ictf_cordic_lane #(
  parameter int unsigned CordicSteps = ictf_pkg::CordicSteps
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] y_i,
  input  logic signed [16:0] x_i,
  output logic               done_o,
  output logic signed [15:0] tilt_o
);

  localparam int unsigned Steps = (CordicSteps < ictf_pkg::TabLen) ?
                                  CordicSteps : ictf_pkg::TabLen;

  logic                               busy_q;
  logic [4:0]                         step_q;
  logic signed [ictf_pkg::VecW-1:0]   x_q, y_q;
  logic signed [ictf_pkg::AngW-1:0]   z_q;
  logic                               done_q;
  logic signed [15:0]                 tilt_q;
  logic signed [ictf_pkg::VecW-1:0]   xs, ys, dx, dy, xe, ye;
  logic signed [ictf_pkg::AngW-1:0]   ta, zt;

  assign xe = ictf_pkg::VecW'(x_i) <<< 8;
  assign ye = ictf_pkg::VecW'(y_i) <<< 8;
  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;
  assign ta = ictf_pkg::AngW'(ictf_pkg::atan_tab(step_q));
  // Truncate toward zero on the divide by 256.
  assign zt = (z_q < 0) ? -((-z_q) >>> 8) : (z_q >>> 8);
  assign xs = x_q;
  assign ys = y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= '0;
        if (y_i == 0) begin
          tilt_q <= (x_i < 0) ? 16'sd1800 : 16'sd0;
          done_q <= 1'b1;
        end else if (x_i == 0) begin
          tilt_q <= (y_i > 0) ? 16'sd900 : -16'sd900;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          if (x_i < 0 && y_i > 0) begin
            x_q <= ye; y_q <= -xe; z_q <= 20'sd230400;
          end else if (x_i < 0) begin
            x_q <= -ye; y_q <= xe; z_q <= -20'sd230400;
          end else begin
            x_q <= xe; y_q <= ye; z_q <= '0;
          end
        end
      end else if (busy_q) begin
        if (step_q == 5'(Steps)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          tilt_q <= 16'(zt);
        end else begin
          step_q <= step_q + 5'd1;
          if (ys >= 0) begin
            x_q <= xs + dx; y_q <= ys - dy; z_q <= z_q + ta;
          end else begin
            x_q <= xs - dx; y_q <= ys + dy; z_q <= z_q - ta;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign tilt_o = tilt_q;

endmodule

FILE: rtl/ictf_merge.sv
// Merging stage: mixes each lane's tilt with the integrated gyro, axis by axis.
module ictf_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ictf_pkg::lane_res_t  lanes_i,
  input  logic signed [15:0]   gx_i, gy_i, gz_i,
  input  logic [31:0]          dt_i,
  input  logic [8:0]           weight_i,
  output logic                 done_o,
  output logic [47:0]          angles_o
);

  // Reciprocal of 1000 scaled by 2^38; exact for any 32-bit magnitude.
  localparam logic [29:0] Recip1000 = 30'd274877907;

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_MUL, S_MIX, S_DIV, S_STORE, S_CONV
  } state_e;

  state_e               state_q;
  logic [1:0]           axis_q;
  logic signed [31:0]   acc_q [3];
  logic signed [15:0]   tilt_q [3];
  logic signed [48:0]   gdt_q;
  logic signed [50:0]   s_q;
  logic signed [51:0]   wt_q;
  logic signed [60:0]   num_q;
  logic signed [31:0]   sat_q;
  logic signed [15:0]   out_q [3];
  logic                 done_q;
  logic signed [15:0]   g_sel;
  logic signed [60:0]   q;
  logic [9:0]           wc, wn;
  logic [31:0]          mag;
  logic [61:0]          prod;
  logic [23:0]          quo;
  logic signed [15:0]   ang;

  assign wc = (weight_i > ictf_pkg::WeightMax) ? 10'd256 : {1'b0, weight_i};
  assign wn = 10'd256 - wc;

  always_comb begin
    case (axis_q)
      2'd0: g_sel = gx_i;
      2'd1: g_sel = gy_i;
      default: g_sel = gz_i;
    endcase
  end

  assign q = (num_q < 0) ? -((-num_q) >>> 8) : (num_q >>> 8);

  // Accumulator to output angle: divide the magnitude by 1000 through a
  // reciprocal multiply, restore the sign and clamp to 16 bits.
  assign mag = sat_q[31] ? 32'(-sat_q) : 32'(sat_q);
  assign prod = 62'(mag) * 62'(Recip1000);
  assign quo = prod[61:38];

  always_comb begin
    if (sat_q[31]) begin
      if (quo > 24'd32768) ang = 16'sh8000;
      else ang = -$signed(quo[15:0]);
    end else begin
      if (quo > 24'd32767) ang = 16'sh7fff;
      else ang = $signed(quo[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      axis_q  <= '0;
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
        out_q[k] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: if (start_i) state_q <= S_WAIT;
        S_WAIT: if (lanes_i.done) begin
          tilt_q[0] <= lanes_i.tilt_x;
          tilt_q[1] <= lanes_i.tilt_y;
          tilt_q[2] <= lanes_i.tilt_z;
          axis_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          gdt_q <= 49'(g_sel) * $signed({1'b0, dt_i});
          wt_q <= $signed({1'b0, wc}) * 32'sd1000 * 52'(tilt_q[axis_q]);
          state_q <= S_MIX;
        end
        S_MIX: begin
          s_q <= 51'(acc_q[axis_q]) + 51'(gdt_q);
          state_q <= S_DIV;
        end
        S_DIV: begin
          num_q <= 61'(s_q) * $signed({1'b0, wn}) + 61'(wt_q);
          state_q <= S_STORE;
        end
        S_STORE: begin
          if (q > 61'sd2147483647) sat_q <= 32'sh7fffffff;
          else if (q < -61'sd2147483648) sat_q <= 32'sh80000000;
          else sat_q <= 32'(q);
          if (q > 61'sd2147483647) acc_q[axis_q] <= 32'sh7fffffff;
          else if (q < -61'sd2147483648) acc_q[axis_q] <= 32'sh80000000;
          else acc_q[axis_q] <= 32'(q);
          state_q <= S_CONV;
        end
        S_CONV: begin
          out_q[axis_q] <= ang;
          if (axis_q == 2'd2) begin
            state_q <= S_IDLE;
            done_q <= 1'b1;
          end else begin
            axis_q <= axis_q + 2'd1;
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign angles_o = {out_q[2], out_q[1], out_q[0]};

endmodule

FILE: rtl/imu_complementary_tilt_filter.sv
// Complementary tilt filter. Each item carries accelerometer and gyro triples
// and a ms timestamp; the first item after reset only records its timestamp.
// Every later item yields one result: it passes the input register and the
// iterative CORDIC lanes, which run side by side for the three axes; the shared
// mixing datapath then treats the axes one after another through its multiply,
// mix, divide, store and convert states, and the output register holds the
// result. Lanes that hit an exact axis case finish at once; the wait is shorter
// only when all three do. One item is in work at a time; a new item is taken
// only after the result has left the output register, so output stalls also
// hold off new items.
module imu_complementary_tilt_filter #(
  parameter int unsigned CORDIC_STEPS = ictf_pkg::CordicSteps
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // angle_x, angle_y, angle_z
  output logic [47:0]  m_axis_tdata
);

  logic [8:0]  weight_q;
  logic        seen_q, busy_q, ovalid_q, start_q;
  logic [31:0] prev_q, dt_q;
  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic [47:0] odata_q, angles;
  logic        mdone, acc_in;
  ictf_pkg::lane_res_t lanes;
  logic dx, dy, dz;

  assign pready = 1'b1;
  assign prdata = {23'd0, weight_q};

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) weight_q <= ictf_pkg::WeightReset;
    else if (psel && penable && pwrite && paddr[2] == ictf_pkg::RegAccelWeight)
      weight_q <= pwdata[8:0];
  end

  assign s_axis_tready = !busy_q && !ovalid_q;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  // Input capture and sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0; busy_q <= 1'b0; prev_q <= '0; start_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (acc_in) begin
        prev_q <= s_axis_tdata[127:96];
        dt_q <= s_axis_tdata[127:96] - prev_q;
        seen_q <= 1'b1;
        {gz_q, gy_q, gx_q, az_q, ay_q, ax_q} <= s_axis_tdata[95:0];
        if (seen_q) begin
          busy_q <= 1'b1; start_q <= 1'b1;
        end
      end
      if (mdone) begin
        busy_q <= 1'b0; ovalid_q <= 1'b1; odata_q <= angles;
      end else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  ictf_cordic_lane #(.CordicSteps(CORDIC_STEPS)) u_lx (
    .clk_i, .rst_ni, .start_i(start_q), .y_i(-17'(ay_q)), .x_i(17'(az_q)),
    .done_o(dx), .tilt_o(lanes.tilt_x));
  ictf_cordic_lane #(.CordicSteps(CORDIC_STEPS)) u_ly (
    .clk_i, .rst_ni, .start_i(start_q), .y_i(-17'(az_q)), .x_i(17'(ax_q)),
    .done_o(dy), .tilt_o(lanes.tilt_y));
  ictf_cordic_lane #(.CordicSteps(CORDIC_STEPS)) u_lz (
    .clk_i, .rst_ni, .start_i(start_q), .y_i(-17'(ay_q)), .x_i(17'(ax_q)),
    .done_o(dz), .tilt_o(lanes.tilt_z));

  // All lanes start together; a special-case lane finishes early and holds.
  logic [2:0] fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_q <= '0;
    else if (start_q || lanes.done) fin_q <= '0;
    else fin_q <= fin_q | {dz, dy, dx};
  end
  assign lanes.done = &(fin_q | {dz, dy, dx});

  ictf_merge u_merge (
    .clk_i, .rst_ni, .start_i(start_q), .lanes_i(lanes),
    .gx_i(gx_q), .gy_i(gy_q), .gz_i(gz_q), .dt_i(dt_q), .weight_i(weight_q),
    .done_o(mdone), .angles_o(angles));

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("out drop");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready) else $error("accept while busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> busy_q) else $error("stray result");

endmodule
